[hdl/olw_pkg.sv]
// Shared types and constants for the order fill level walker.
// Used by the front, queue, back and top-level modules; depends on nothing.
package olw_pkg;

  localparam int PX_W  = 20;
  localparam int QTY_W = 16;
  localparam int OID_W = 32;
  localparam int SID_W = 16;
  localparam int MSG_W = 32;
  localparam int SLP_W = 8;

  localparam logic [PX_W-1:0] PX_MAX = {PX_W{1'b1}};

  localparam int MAX_FILLS_DEF = 63;

  // Queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIAN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIP   = 1'b1;

  localparam logic OP_SNAP  = 1'b0;
  localparam logic OP_ORDER = 1'b1;

  localparam logic KIND_FILL = 1'b0;
  localparam logic KIND_REST = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic             is_snap;
    logic [PX_W-1:0]  bid_px;
    logic [QTY_W-1:0] bid_qty;
    logic [PX_W-1:0]  ask_px;
    logic [QTY_W-1:0] ask_qty;
    logic             side;
    logic [QTY_W-1:0] qty;
    logic             is_limit;
    logic [PX_W-1:0]  limit_px;
    logic [OID_W-1:0] order_id;
    logic [SID_W-1:0] strat_id;
  } q_entry_t;

  // Front to queue, and queue to back.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_xfer_t;

endpackage

[hdl/order_fill_level_walker.sv]
// Top level of the order fill level walker: configuration registers and
// the front, queue and back instances. Depends on olw_pkg and its submodules.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     op, snapshot fields, order fields
//   out      output     out_valid / out_stall   kind, ids, side, qty, px, msg id, last
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// An item is held in the front register and then written into the queue before the
// back takes it. The back loads a snapshot as it picks it up; an order is walked step
// by step: a step per fill, per empty level met before a fill, and for a rest record.
// The back walks a single order at a time through its fill loop.
// Reset is synchronous and clears control state and the book state.
// An output stall holds back new records; the front keeps taking items until the queue and its register fill.
module order_fill_level_walker import olw_pkg::*; #(
  parameter int MAX_FILLS = MAX_FILLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [PX_W-1:0]      in_best_bid_px,
  input  logic [QTY_W-1:0]     in_best_bid_qty,
  input  logic [PX_W-1:0]      in_best_ask_px,
  input  logic [QTY_W-1:0]     in_best_ask_qty,
  input  logic                 in_order_side,
  input  logic [QTY_W-1:0]     in_order_qty,
  input  logic                 in_order_is_limit,
  input  logic [PX_W-1:0]      in_limit_px,
  input  logic [OID_W-1:0]     in_order_id,
  input  logic [SID_W-1:0]     in_strat_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [OID_W-1:0]     out_order_id,
  output logic [SID_W-1:0]     out_strat_id,
  output logic                 out_side,
  output logic [QTY_W-1:0]     out_qty,
  output logic [PX_W-1:0]      out_px,
  output logic [MSG_W-1:0]     out_message_id,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [QTY_W-1:0]     cfg_wdata
);

  logic [QTY_W-1:0] median_r;
  logic [SLP_W-1:0] slip_r;
  logic [QTY_W-1:0] median_eff;
  q_xfer_t          push, head;
  logic             q_full, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      median_r <= QTY_W'(1);
      slip_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MEDIAN: median_r <= cfg_wdata;
        CFG_SLIP:   slip_r   <= cfg_wdata[SLP_W-1:0];
        default:    median_r <= median_r;
      endcase
    end
  end

  // A median of zero would never let a level drain; it counts as one.
  assign median_eff = (median_r == '0) ? QTY_W'(1) : median_r;

  olw_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_best_bid_px    (in_best_bid_px),
    .in_best_bid_qty   (in_best_bid_qty),
    .in_best_ask_px    (in_best_ask_px),
    .in_best_ask_qty   (in_best_ask_qty),
    .in_order_side     (in_order_side),
    .in_order_qty      (in_order_qty),
    .in_order_is_limit (in_order_is_limit),
    .in_limit_px       (in_limit_px),
    .in_order_id       (in_order_id),
    .in_strat_id       (in_strat_id),
    .push              (push),
    .q_full            (q_full)
  );

  olw_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  olw_back #(
    .MAX_FILLS (MAX_FILLS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .median         (median_eff),
    .slippage       (slip_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_order_id   (out_order_id),
    .out_strat_id   (out_strat_id),
    .out_side       (out_side),
    .out_qty        (out_qty),
    .out_px         (out_px),
    .out_message_id (out_message_id),
    .out_last       (out_last)
  );

endmodule

[hdl/olw_front.sv]
// Input stage: accepts items, drops orders of zero quantity, and holds
// one classified item until the queue takes it. Depends on olw_pkg.
module olw_front import olw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_op,
  input  logic [PX_W-1:0]  in_best_bid_px,
  input  logic [QTY_W-1:0] in_best_bid_qty,
  input  logic [PX_W-1:0]  in_best_ask_px,
  input  logic [QTY_W-1:0] in_best_ask_qty,
  input  logic             in_order_side,
  input  logic [QTY_W-1:0] in_order_qty,
  input  logic             in_order_is_limit,
  input  logic [PX_W-1:0]  in_limit_px,
  input  logic [OID_W-1:0] in_order_id,
  input  logic [SID_W-1:0] in_strat_id,
  output q_xfer_t          push,
  input  logic             q_full
);

  logic     valid_r, valid_nxt;
  q_entry_t entry_r;
  logic     accept;
  logic     keep;

  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  // An order with nothing to fill produces no result and touches no state.
  assign keep     = (in_op == OP_SNAP) || (in_order_qty != '0);

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && !q_full) begin
      valid_nxt = 1'b0;
    end
    if (accept && keep) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      entry_r.is_snap  <= (in_op == OP_SNAP);
      entry_r.bid_px   <= in_best_bid_px;
      entry_r.bid_qty  <= in_best_bid_qty;
      entry_r.ask_px   <= in_best_ask_px;
      entry_r.ask_qty  <= in_best_ask_qty;
      entry_r.side     <= in_order_side;
      entry_r.qty      <= in_order_qty;
      entry_r.is_limit <= in_order_is_limit;
      entry_r.limit_px <= in_limit_px;
      entry_r.order_id <= in_order_id;
      entry_r.strat_id <= in_strat_id;
    end
  end

  assign push.valid = valid_r;
  assign push.entry = entry_r;

endmodule

[hdl/olw_queue.sv]
// Short FIFO between the front and the back of the walker.
// Depends on olw_pkg.
module olw_queue import olw_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_xfer_t push,
  output logic    full,
  output q_xfer_t head,
  input  logic    pop
);

  q_entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

endmodule

[hdl/olw_back.sv]
// Execution side: holds the book snapshot and depth levels, walks one order a fill
// per cycle unless the output stalls, drives the result register. Depends on olw_pkg.
module olw_back import olw_pkg::*; #(
  parameter int MAX_FILLS = MAX_FILLS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_xfer_t          head,
  output logic             pop,
  input  logic [QTY_W-1:0] median,
  input  logic [SLP_W-1:0] slippage,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [OID_W-1:0] out_order_id,
  output logic [SID_W-1:0] out_strat_id,
  output logic             out_side,
  output logic [QTY_W-1:0] out_qty,
  output logic [PX_W-1:0]  out_px,
  output logic [MSG_W-1:0] out_message_id,
  output logic             out_last
);

  localparam int FILL_W = $clog2(MAX_FILLS + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic state_r, state_nxt;

  logic [PX_W-1:0]  snap_bid_r, snap_ask_r;
  logic [PX_W-1:0]  bid_level_r, ask_level_r, bid_level_nxt, ask_level_nxt;
  logic [QTY_W-1:0] bid_left_r, ask_left_r, bid_left_nxt, ask_left_nxt;
  logic [MSG_W-1:0] msg_cnt_r, msg_cnt_nxt;

  logic             side_r, lim_r;
  logic [PX_W-1:0]  limit_r;
  logic [QTY_W-1:0] rem_r, rem_nxt;
  logic [OID_W-1:0] oid_r;
  logic [SID_W-1:0] sid_r;
  logic [FILL_W-1:0] fills_r, fills_nxt;

  logic             ov_r, ov_nxt;
  logic             emit;
  logic             e_kind, e_last;
  logic [QTY_W-1:0] e_qty;
  logic [PX_W-1:0]  e_px;
  logic [MSG_W-1:0] e_msg;

  logic             out_free;
  logic [PX_W-1:0]  level, level_inc;
  logic [QTY_W-1:0] left, exec, left_after, rem_after;
  logic signed [PX_W+1:0] lp, lim_s;
  logic signed [PX_W+2:0] fp;
  logic [PX_W-1:0]  fp_clamped;
  logic             brk;

  assign out_free = !ov_r || !out_stall;

  assign level     = side_r ? bid_level_r : ask_level_r;
  assign left      = side_r ? bid_left_r : ask_left_r;
  assign level_inc = (level != PX_MAX) ? level + 1'b1 : level;

  // Level price without slippage; a sell can go below zero.
  assign lp = side_r ? $signed({2'b00, snap_bid_r}) - $signed({2'b00, level})
                     : $signed({2'b00, snap_ask_r}) + $signed({2'b00, level});
  assign lim_s = $signed({2'b00, limit_r});
  assign brk   = lim_r && (side_r ? (lim_s > lp) : (lim_s < lp));

  assign fp = side_r ? {lp[PX_W+1], lp} - $signed({{(PX_W-SLP_W+3){1'b0}}, slippage})
                     : {lp[PX_W+1], lp} + $signed({{(PX_W-SLP_W+3){1'b0}}, slippage});

  always_comb begin
    if (fp[PX_W+2]) begin
      fp_clamped = '0;
    end else if (fp > $signed({3'b000, PX_MAX})) begin
      fp_clamped = PX_MAX;
    end else begin
      fp_clamped = fp[PX_W-1:0];
    end
  end

  assign exec       = (rem_r < left) ? rem_r : left;
  assign left_after = left - exec;
  assign rem_after  = rem_r - exec;

  always_comb begin
    state_nxt     = state_r;
    pop           = 1'b0;
    bid_level_nxt = bid_level_r;
    ask_level_nxt = ask_level_r;
    bid_left_nxt  = bid_left_r;
    ask_left_nxt  = ask_left_r;
    msg_cnt_nxt   = msg_cnt_r;
    rem_nxt       = rem_r;
    fills_nxt     = fills_r;
    emit          = 1'b0;
    e_kind        = KIND_FILL;
    e_last        = 1'b0;
    e_qty         = rem_r;
    e_px          = '0;
    e_msg         = '0;

    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.entry.is_snap) begin
            bid_level_nxt = '0;
            ask_level_nxt = '0;
            bid_left_nxt  = head.entry.bid_qty;
            ask_left_nxt  = head.entry.ask_qty;
          end else begin
            rem_nxt   = head.entry.qty;
            fills_nxt = '0;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (fills_r == FILL_W'(MAX_FILLS)) begin
          // Fill cap reached with quantity left over.
          if (out_free) begin
            emit      = 1'b1;
            e_kind    = KIND_REST;
            e_last    = 1'b1;
            e_px      = lim_r ? limit_r : '0;
            state_nxt = ST_IDLE;
          end
        end else if (left == '0) begin
          // Empty top level: step deeper without a record.
          if (side_r) begin
            bid_left_nxt  = median;
            bid_level_nxt = level_inc;
          end else begin
            ask_left_nxt  = median;
            ask_level_nxt = level_inc;
          end
        end else if (brk) begin
          if (out_free) begin
            emit      = 1'b1;
            e_kind    = KIND_REST;
            e_last    = 1'b1;
            e_px      = limit_r;
            state_nxt = ST_IDLE;
          end
        end else if (out_free) begin
          emit        = 1'b1;
          e_kind      = KIND_FILL;
          e_qty       = exec;
          e_px        = fp_clamped;
          e_msg       = msg_cnt_r;
          e_last      = (rem_after == '0);
          msg_cnt_nxt = msg_cnt_r + 1'b1;
          rem_nxt     = rem_after;
          fills_nxt   = fills_r + 1'b1;
          if (side_r) begin
            bid_left_nxt = (left_after == '0) ? median : left_after;
            if (left_after == '0) begin
              bid_level_nxt = level_inc;
            end
          end else begin
            ask_left_nxt = (left_after == '0) ? median : left_after;
            if (left_after == '0) begin
              ask_level_nxt = level_inc;
            end
          end
          if (rem_after == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_free) begin
      ov_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ov_r        <= 1'b0;
      snap_bid_r  <= '0;
      snap_ask_r  <= '0;
      bid_level_r <= '0;
      ask_level_r <= '0;
      bid_left_r  <= '0;
      ask_left_r  <= '0;
      msg_cnt_r   <= '0;
      rem_r       <= '0;
      fills_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      ov_r        <= ov_nxt;
      bid_level_r <= bid_level_nxt;
      ask_level_r <= ask_level_nxt;
      bid_left_r  <= bid_left_nxt;
      ask_left_r  <= ask_left_nxt;
      msg_cnt_r   <= msg_cnt_nxt;
      rem_r       <= rem_nxt;
      fills_r     <= fills_nxt;
      if (pop && head.entry.is_snap) begin
        snap_bid_r <= head.entry.bid_px;
        snap_ask_r <= head.entry.ask_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !head.entry.is_snap) begin
      side_r  <= head.entry.side;
      lim_r   <= head.entry.is_limit;
      limit_r <= head.entry.limit_px;
      oid_r   <= head.entry.order_id;
      sid_r   <= head.entry.strat_id;
    end
    if (emit) begin
      out_kind       <= e_kind;
      out_order_id   <= oid_r;
      out_strat_id   <= sid_r;
      out_side       <= side_r;
      out_qty        <= e_qty;
      out_px         <= e_px;
      out_message_id <= e_msg;
      out_last       <= e_last;
    end
  end

  assign out_valid = ov_r;

endmodule
